// ----- hw/rtl/event_report_filter_macros.svh -----
// assertion macros shared by the event report filter modules
// expects clk and rst_n in the scope of each use
`ifndef EVENT_REPORT_FILTER_MACROS_SVH
`define EVENT_REPORT_FILTER_MACROS_SVH

// same-cycle implication
`define ERF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event_report_filter check failed");

// next-cycle implication
`define ERF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event_report_filter check failed");

`endif

// ----- hw/rtl/erf_pkg.sv -----
// shared types, codes and constants of the event report filter
// no dependencies
package erf_pkg;

  localparam int unsigned MAX_EVENT_IDS_DEF = 64;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_HEADER = 2'd1,
    OP_DATA   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_TC     = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNKNOWN_EVT = 3'd1,
    ST_BAD_PARAM   = 3'd2,
    ST_BAD_LENGTH  = 3'd3,
    ST_BAD_SUBTYPE = 3'd4
  } status_t;

  localparam logic [7:0] SUB_ENABLE  = 8'd5;
  localparam logic [7:0] SUB_DISABLE = 8'd6;
  localparam logic [7:0] SEV_MIN     = 8'd1;
  localparam logic [7:0] SEV_MAX     = 8'd4;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic load;
    logic exec;
  } erf_cmd_t;

  typedef struct packed {
    logic has_result;
  } erf_sts_t;

endpackage

// ----- hw/rtl/event_report_filter.sv -----
// top level of the event report filter
// depends on erf_pkg, erf_ctrl and erf_dp
//
// Each accepted item is registered in the idle state and, in the exec state, checked
// against the enable mask and collection state, which it then updates; in_ready is
// high only in the idle state. A result is held in an output register, so the next
// item is taken while it waits; only an item that itself yields a result
// waits in the exec state until that register is free. Reports and queries
// always give one result, telecommand headers only when rejected, data bytes
// only at the final byte of a list. All enable bits are set after reset.
module event_report_filter #(
  parameter int unsigned MAX_EVENT_IDS = erf_pkg::MAX_EVENT_IDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_event_id,
  input  logic [7:0]  in_severity,
  input  logic [15:0] in_aux_word,
  input  logic [7:0]  in_tc_subtype,
  input  logic [15:0] in_tc_length,
  input  logic [7:0]  in_tc_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_status,
  output logic        out_tm_emit,
  output logic [2:0]  out_tm_severity,
  output logic [15:0] out_tm_event_id,
  output logic [15:0] out_tm_aux,
  output logic        out_is_enabled
);

  erf_pkg::erf_cmd_t cmd;
  erf_pkg::erf_sts_t sts;

  erf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  erf_dp #(
    .MAX_EVENT_IDS(MAX_EVENT_IDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_event_id     (in_event_id),
    .in_severity     (in_severity),
    .in_aux_word     (in_aux_word),
    .in_tc_subtype   (in_tc_subtype),
    .in_tc_length    (in_tc_length),
    .in_tc_byte      (in_tc_byte),
    .out_result_kind (out_result_kind),
    .out_status      (out_status),
    .out_tm_emit     (out_tm_emit),
    .out_tm_severity (out_tm_severity),
    .out_tm_event_id (out_tm_event_id),
    .out_tm_aux      (out_tm_aux),
    .out_is_enabled  (out_is_enabled)
  );

endmodule

// ----- hw/rtl/erf_ctrl.sv -----
// controller of the event report filter: item sequencing and result handshake
// depends on erf_pkg and event_report_filter_macros.svh
`include "event_report_filter_macros.svh"
module erf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output erf_pkg::erf_cmd_t cmd,
  input  erf_pkg::erf_sts_t sts
);

  erf_pkg::fsm_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= erf_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      erf_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = erf_pkg::FSM_EXEC;
        end
      end
      erf_pkg::FSM_EXEC: begin
        // hold an item that yields a result while the result slot is still full
        if (!sts.has_result || !out_valid_r || out_ready) begin
          cmd.exec  = 1'b1;
          state_nxt = erf_pkg::FSM_IDLE;
          if (sts.has_result) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = erf_pkg::FSM_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `ERF_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_r == erf_pkg::FSM_EXEC)
  `ERF_ASSERT_NOW(a_no_overwrite, cmd.exec && sts.has_result, !out_valid_r || out_ready)

endmodule

// ----- hw/rtl/erf_dp.sv -----
// datapath of the event report filter: item registers, masks, collection state
// and result register; depends on erf_pkg and event_report_filter_macros.svh
`include "event_report_filter_macros.svh"
module erf_dp #(
  parameter int unsigned MAX_EVENT_IDS = erf_pkg::MAX_EVENT_IDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  erf_pkg::erf_cmd_t cmd,
  output erf_pkg::erf_sts_t sts,
  input  logic [1:0]        in_op,
  input  logic [15:0]       in_event_id,
  input  logic [7:0]        in_severity,
  input  logic [15:0]       in_aux_word,
  input  logic [7:0]        in_tc_subtype,
  input  logic [15:0]       in_tc_length,
  input  logic [7:0]        in_tc_byte,
  output logic [1:0]        out_result_kind,
  output logic [2:0]        out_status,
  output logic              out_tm_emit,
  output logic [2:0]        out_tm_severity,
  output logic [15:0]       out_tm_event_id,
  output logic [15:0]       out_tm_aux,
  output logic              out_is_enabled
);

  localparam int unsigned IDX_W = (MAX_EVENT_IDS > 1) ? $clog2(MAX_EVENT_IDS) : 1;
  localparam logic [15:0] MAX_ID = 16'(MAX_EVENT_IDS);

  // item registers
  erf_pkg::op_t op_r;
  logic [15:0]  id_r;
  logic [7:0]   sev_r;
  logic [15:0]  aux_r;
  logic [7:0]   sub_r;
  logic [15:0]  len_r;
  logic [7:0]   byte_r;

  // filter and collection state
  logic [MAX_EVENT_IDS-1:0] enable_mask_r, enable_mask_nxt;
  logic [MAX_EVENT_IDS-1:0] pending_mask_r, pending_mask_nxt;
  logic        tc_active_r, tc_active_nxt;
  logic        tc_is_enable_r, tc_is_enable_nxt;
  logic [15:0] bytes_expected_r, bytes_expected_nxt;
  logic [15:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0]  list_count_r, list_count_nxt;
  logic [7:0]  id_high_byte_r, id_high_byte_nxt;
  logic        bad_id_seen_r, bad_id_seen_nxt;

  // result register
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        emit_r, emit_nxt;
  logic [2:0]  tm_sev_r, tm_sev_nxt;
  logic [15:0] tm_id_r, tm_id_nxt;
  logic [15:0] tm_aux_r, tm_aux_nxt;
  logic        is_en_r, is_en_nxt;

  logic             has_result;
  logic             id_ok, sev_ok, id_en, sub_ok;
  logic [IDX_W-1:0] id_idx, lid_idx;
  logic [15:0]      lid, seen_inc;
  logic             lid_ok, last_byte;
  logic [16:0]      len_want;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= erf_pkg::op_t'(in_op);
      id_r   <= in_event_id;
      sev_r  <= in_severity;
      aux_r  <= in_aux_word;
      sub_r  <= in_tc_subtype;
      len_r  <= in_tc_length;
      byte_r <= in_tc_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && has_result) begin
      kind_r   <= kind_nxt;
      status_r <= status_nxt;
      emit_r   <= emit_nxt;
      tm_sev_r <= tm_sev_nxt;
      tm_id_r  <= tm_id_nxt;
      tm_aux_r <= tm_aux_nxt;
      is_en_r  <= is_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r    <= '1;
      pending_mask_r   <= '0;
      tc_active_r      <= 1'b0;
      tc_is_enable_r   <= 1'b0;
      bytes_expected_r <= '0;
      bytes_seen_r     <= '0;
      list_count_r     <= '0;
      id_high_byte_r   <= '0;
      bad_id_seen_r    <= 1'b0;
    end else if (cmd.exec) begin
      enable_mask_r    <= enable_mask_nxt;
      pending_mask_r   <= pending_mask_nxt;
      tc_active_r      <= tc_active_nxt;
      tc_is_enable_r   <= tc_is_enable_nxt;
      bytes_expected_r <= bytes_expected_nxt;
      bytes_seen_r     <= bytes_seen_nxt;
      list_count_r     <= list_count_nxt;
      id_high_byte_r   <= id_high_byte_nxt;
      bad_id_seen_r    <= bad_id_seen_nxt;
    end
  end

  always_comb begin
    id_ok     = (id_r != 16'd0) && (id_r <= MAX_ID);
    sev_ok    = (sev_r >= erf_pkg::SEV_MIN) && (sev_r <= erf_pkg::SEV_MAX);
    id_idx    = IDX_W'(id_r - 16'd1);
    id_en     = id_ok && enable_mask_r[id_idx];
    sub_ok    = (sub_r == erf_pkg::SUB_ENABLE) || (sub_r == erf_pkg::SUB_DISABLE);
    lid       = {id_high_byte_r, byte_r};
    lid_ok    = (lid != 16'd0) && (lid <= MAX_ID);
    lid_idx   = IDX_W'(lid - 16'd1);
    seen_inc  = bytes_seen_r + 16'd1;
    last_byte = (seen_inc == bytes_expected_r);
    len_want  = '0;

    enable_mask_nxt    = enable_mask_r;
    pending_mask_nxt   = pending_mask_r;
    tc_active_nxt      = tc_active_r;
    tc_is_enable_nxt   = tc_is_enable_r;
    bytes_expected_nxt = bytes_expected_r;
    bytes_seen_nxt     = bytes_seen_r;
    list_count_nxt     = list_count_r;
    id_high_byte_nxt   = id_high_byte_r;
    bad_id_seen_nxt    = bad_id_seen_r;

    has_result = 1'b0;
    kind_nxt   = erf_pkg::KIND_REPORT;
    status_nxt = erf_pkg::ST_OK;
    emit_nxt   = 1'b0;
    tm_sev_nxt = '0;
    tm_id_nxt  = '0;
    tm_aux_nxt = '0;
    is_en_nxt  = 1'b0;

    unique case (op_r)
      erf_pkg::OP_REPORT: begin
        has_result = 1'b1;
        if (!id_ok) begin
          status_nxt = erf_pkg::ST_UNKNOWN_EVT;
        end else if (!sev_ok) begin
          status_nxt = erf_pkg::ST_BAD_PARAM;
        end else if (id_en) begin
          emit_nxt   = 1'b1;
          tm_sev_nxt = sev_r[2:0];
          tm_id_nxt  = id_r;
          tm_aux_nxt = aux_r;
        end
      end
      erf_pkg::OP_QUERY: begin
        has_result = 1'b1;
        kind_nxt   = erf_pkg::KIND_QUERY;
        is_en_nxt  = id_en;
      end
      erf_pkg::OP_HEADER: begin
        kind_nxt           = erf_pkg::KIND_TC;
        pending_mask_nxt   = '0;
        tc_active_nxt      = 1'b0;
        tc_is_enable_nxt   = 1'b0;
        bytes_expected_nxt = '0;
        bytes_seen_nxt     = '0;
        list_count_nxt     = '0;
        id_high_byte_nxt   = '0;
        bad_id_seen_nxt    = 1'b0;
        if (!sub_ok) begin
          has_result = 1'b1;
          status_nxt = erf_pkg::ST_BAD_SUBTYPE;
        end else if (len_r == 16'd0) begin
          has_result = 1'b1;
          status_nxt = erf_pkg::ST_BAD_LENGTH;
        end else begin
          tc_active_nxt      = 1'b1;
          tc_is_enable_nxt   = (sub_r == erf_pkg::SUB_ENABLE);
          bytes_expected_nxt = len_r;
        end
      end
      erf_pkg::OP_DATA: begin
        kind_nxt = erf_pkg::KIND_TC;
        if (tc_active_r) begin
          if (bytes_seen_r == 16'd0) begin
            list_count_nxt = byte_r;
          end else if (bytes_seen_r[0]) begin
            id_high_byte_nxt = byte_r;
          end else if (lid_ok) begin
            pending_mask_nxt[lid_idx] = 1'b1;
          end else begin
            bad_id_seen_nxt = 1'b1;
          end
          bytes_seen_nxt = seen_inc;
          if (last_byte) begin
            has_result = 1'b1;
            len_want   = {8'd0, list_count_nxt, 1'b1};
            if ({1'b0, bytes_expected_r} != len_want) begin
              status_nxt = erf_pkg::ST_BAD_LENGTH;
            end else if (list_count_nxt == 8'd0) begin
              status_nxt = erf_pkg::ST_BAD_PARAM;
            end else if (bad_id_seen_nxt) begin
              status_nxt = erf_pkg::ST_UNKNOWN_EVT;
            end else if (tc_is_enable_r) begin
              enable_mask_nxt = enable_mask_r | pending_mask_nxt;
            end else begin
              enable_mask_nxt = enable_mask_r & ~pending_mask_nxt;
            end
            pending_mask_nxt   = '0;
            tc_active_nxt      = 1'b0;
            tc_is_enable_nxt   = 1'b0;
            bytes_expected_nxt = '0;
            bytes_seen_nxt     = '0;
            list_count_nxt     = '0;
            id_high_byte_nxt   = '0;
            bad_id_seen_nxt    = 1'b0;
          end
        end
      end
      default: has_result = 1'b0;
    endcase
  end

  assign sts.has_result  = has_result;
  assign out_result_kind = kind_r;
  assign out_status      = status_r;
  assign out_tm_emit     = emit_r;
  assign out_tm_severity = tm_sev_r;
  assign out_tm_event_id = tm_id_r;
  assign out_tm_aux      = tm_aux_r;
  assign out_is_enabled  = is_en_r;

  `ERF_ASSERT_NOW(a_idle_clean, !tc_active_r, (bytes_seen_r == 16'd0) && (pending_mask_r == '0))
  `ERF_ASSERT_NOW(a_seen_below, tc_active_r, bytes_seen_r < bytes_expected_r)

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for event_report_filter: reports, queries and enable/disable lists
// predicts each result from its own copy of the enable mask and list collection state
// depends on erf_pkg and the event_report_filter rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_IDS = erf_pkg::MAX_EVENT_IDS_DEF;

  typedef struct {
    erf_pkg::op_t op;
    logic [15:0]  event_id;
    logic [7:0]   severity;
    logic [15:0]  aux;
    logic [7:0]   subtype;
    logic [15:0]  length;
    logic [7:0]   data;
  } erf_item_t;

  typedef struct {
    erf_pkg::kind_t   kind;
    erf_pkg::status_t status;
    logic             tm_emit;
    logic [2:0]       tm_severity;
    logic [15:0]      tm_event_id;
    logic [15:0]      tm_aux;
    logic             is_enabled;
  } filter_outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [15:0] in_event_id;
  logic [7:0]  in_severity;
  logic [15:0] in_aux_word;
  logic [7:0]  in_tc_subtype;
  logic [15:0] in_tc_length;
  logic [7:0]  in_tc_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_result_kind;
  logic [2:0]  out_status;
  logic        out_tm_emit;
  logic [2:0]  out_tm_severity;
  logic [15:0] out_tm_event_id;
  logic [15:0] out_tm_aux;
  logic        out_is_enabled;

  // predictor state
  logic [63:0] enable_mask;
  logic [63:0] pending_mask;
  logic        tc_active;
  logic        tc_enable;
  logic [15:0] bytes_expected;
  logic [15:0] bytes_seen;
  logic [7:0]  list_count;
  logic [7:0]  id_high;
  logic        bad_id_seen;

  filter_outcome_t awaited_outcomes[$];

  int  mismatches;
  int  n_items;
  int  n_checked;
  int  n_emitted;
  int  n_lists_applied;
  bit  calm;

  event_report_filter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_event_id     (in_event_id),
    .in_severity     (in_severity),
    .in_aux_word     (in_aux_word),
    .in_tc_subtype   (in_tc_subtype),
    .in_tc_length    (in_tc_length),
    .in_tc_byte      (in_tc_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_status      (out_status),
    .out_tm_emit     (out_tm_emit),
    .out_tm_severity (out_tm_severity),
    .out_tm_event_id (out_tm_event_id),
    .out_tm_aux      (out_tm_aux),
    .out_is_enabled  (out_is_enabled)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
  endtask

  always @(posedge clk) begin : result_checker
    filter_outcome_t exp_o;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result with nothing awaited, kind", 16'(out_result_kind), 16'd0);
      end else begin
        exp_o = awaited_outcomes.pop_front();
        n_checked++;
        if (out_result_kind !== exp_o.kind)
          report_mismatch("result kind", 16'(out_result_kind), 16'(exp_o.kind));
        if (out_status !== exp_o.status)
          report_mismatch("status", 16'(out_status), 16'(exp_o.status));
        if (out_tm_emit !== exp_o.tm_emit)
          report_mismatch("tm_emit", 16'(out_tm_emit), 16'(exp_o.tm_emit));
        if (out_tm_severity !== exp_o.tm_severity)
          report_mismatch("tm_severity", 16'(out_tm_severity), 16'(exp_o.tm_severity));
        if (out_tm_event_id !== exp_o.tm_event_id)
          report_mismatch("tm_event_id", out_tm_event_id, exp_o.tm_event_id);
        if (out_tm_aux !== exp_o.tm_aux)
          report_mismatch("tm_aux", out_tm_aux, exp_o.tm_aux);
        if (out_is_enabled !== exp_o.is_enabled)
          report_mismatch("is_enabled", 16'(out_is_enabled), 16'(exp_o.is_enabled));
      end
    end
  end

  function automatic bit id_valid(input logic [15:0] id);
    return (id >= 16'd1) && (id <= MAX_IDS);
  endfunction

  function automatic void clear_collection();
    pending_mask   = '0;
    tc_active      = 1'b0;
    tc_enable      = 1'b0;
    bytes_expected = '0;
    bytes_seen     = '0;
    list_count     = '0;
    id_high        = '0;
    bad_id_seen    = 1'b0;
  endfunction

  task automatic evaluate_item(input erf_item_t it, output bit ignored);
    filter_outcome_t o;
    bit              has;
    logic [15:0]     lid;
    o.kind        = erf_pkg::KIND_REPORT;
    o.status      = erf_pkg::ST_OK;
    o.tm_emit     = 1'b0;
    o.tm_severity = '0;
    o.tm_event_id = '0;
    o.tm_aux      = '0;
    o.is_enabled  = 1'b0;
    has     = 1'b0;
    ignored = 1'b0;
    case (it.op)
      erf_pkg::OP_REPORT: begin
        has = 1'b1;
        if (!id_valid(it.event_id)) begin
          o.status = erf_pkg::ST_UNKNOWN_EVT;
        end else if (it.severity < erf_pkg::SEV_MIN || it.severity > erf_pkg::SEV_MAX) begin
          o.status = erf_pkg::ST_BAD_PARAM;
        end else if (enable_mask[6'(it.event_id - 16'd1)]) begin
          o.tm_emit     = 1'b1;
          o.tm_severity = it.severity[2:0];
          o.tm_event_id = it.event_id;
          o.tm_aux      = it.aux;
          n_emitted++;
        end
      end
      erf_pkg::OP_QUERY: begin
        has    = 1'b1;
        o.kind = erf_pkg::KIND_QUERY;
        o.is_enabled = id_valid(it.event_id) && enable_mask[6'(it.event_id - 16'd1)];
      end
      erf_pkg::OP_HEADER: begin
        clear_collection();
        o.kind = erf_pkg::KIND_TC;
        if (it.subtype != erf_pkg::SUB_ENABLE && it.subtype != erf_pkg::SUB_DISABLE) begin
          has      = 1'b1;
          o.status = erf_pkg::ST_BAD_SUBTYPE;
        end else if (it.length == 16'd0) begin
          has      = 1'b1;
          o.status = erf_pkg::ST_BAD_LENGTH;
        end else begin
          tc_active      = 1'b1;
          tc_enable      = (it.subtype == erf_pkg::SUB_ENABLE);
          bytes_expected = it.length;
        end
      end
      erf_pkg::OP_DATA: begin
        if (!tc_active) begin
          ignored = 1'b1;
        end else begin
          if (bytes_seen == 16'd0) begin
            list_count = it.data;
          end else if (bytes_seen[0]) begin
            id_high = it.data;
          end else begin
            lid = {id_high, it.data};
            if (id_valid(lid))
              pending_mask[6'(lid - 16'd1)] = 1'b1;
            else
              bad_id_seen = 1'b1;
          end
          bytes_seen = bytes_seen + 16'd1;
          if (bytes_seen == bytes_expected) begin
            has    = 1'b1;
            o.kind = erf_pkg::KIND_TC;
            if (int'(bytes_expected) != 1 + 2 * int'(list_count)) begin
              o.status = erf_pkg::ST_BAD_LENGTH;
            end else if (list_count == 8'd0) begin
              o.status = erf_pkg::ST_BAD_PARAM;
            end else if (bad_id_seen) begin
              o.status = erf_pkg::ST_UNKNOWN_EVT;
            end else begin
              if (tc_enable)
                enable_mask = enable_mask | pending_mask;
              else
                enable_mask = enable_mask & ~pending_mask;
              n_lists_applied++;
            end
            clear_collection();
          end
        end
      end
    endcase
    if (has)
      awaited_outcomes.push_back(o);
  endtask

  task automatic send_item(input erf_item_t it);
    bit ignored;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (!calm && $urandom_range(99) < 38);
    end
    in_valid      <= 1'b1;
    in_op         <= it.op;
    in_event_id   <= it.event_id;
    in_severity   <= it.severity;
    in_aux_word   <= it.aux;
    in_tc_subtype <= it.subtype;
    in_tc_length  <= it.length;
    in_tc_byte    <= it.data;
    do @(posedge clk); while (!in_ready);
    evaluate_item(it, ignored);
    if (!ignored)
      n_items++;
  endtask

  function automatic erf_item_t make_item(input erf_pkg::op_t op);
    erf_item_t it;
    it.op       = op;
    it.event_id = 16'($urandom);
    it.severity = 8'($urandom);
    it.aux      = 16'($urandom);
    it.subtype  = 8'($urandom);
    it.length   = 16'($urandom);
    it.data     = 8'($urandom);
    return it;
  endfunction

  task automatic send_report(input logic [15:0] id, input logic [7:0] sev);
    erf_item_t it;
    it = make_item(erf_pkg::OP_REPORT);
    it.event_id = id;
    it.severity = sev;
    send_item(it);
  endtask

  task automatic send_query(input logic [15:0] id);
    erf_item_t it;
    it = make_item(erf_pkg::OP_QUERY);
    it.event_id = id;
    send_item(it);
  endtask

  task automatic send_header(input logic [7:0] sub, input logic [15:0] len);
    erf_item_t it;
    it = make_item(erf_pkg::OP_HEADER);
    it.subtype = sub;
    it.length  = len;
    send_item(it);
  endtask

  task automatic send_data(input logic [7:0] b);
    erf_item_t it;
    it = make_item(erf_pkg::OP_DATA);
    it.data = b;
    send_item(it);
  endtask

  function automatic logic [15:0] pick_event_id(input int valid_pct);
    if ($urandom_range(99) < valid_pct)
      return 16'($urandom_range(MAX_IDS, 1));
    case ($urandom_range(2))
      0:       return 16'd0;
      1:       return 16'(MAX_IDS + 1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_severity();
    if ($urandom_range(4) == 0)
      return 8'($urandom);
    return 8'($urandom_range(erf_pkg::SEV_MAX, erf_pkg::SEV_MIN));
  endfunction

  // reports and queries may be mingled between the bytes of a list
  task automatic send_telecommand(input logic [7:0] sub, input logic [15:0] len,
                                  input logic [7:0] bytes[$], input bit mingle);
    send_header(sub, len);
    foreach (bytes[i]) begin
      if (mingle && $urandom_range(99) < 12) begin
        if ($urandom_range(1))
          send_report(pick_event_id(85), pick_severity());
        else
          send_query(pick_event_id(85));
      end
      send_data(bytes[i]);
    end
  endtask

  task automatic hold_until_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic test_reports();
    send_report(16'd0, 8'd1);
    send_report(16'd1, 8'd1);
    send_report(16'(MAX_IDS), erf_pkg::SEV_MAX);
    send_report(16'(MAX_IDS + 1), erf_pkg::SEV_MAX);
    send_report(16'd1, 8'd0);
    send_report(16'd2, 8'd5);
  endtask

  task automatic test_queries();
    send_query(16'd0);
    send_query(16'(MAX_IDS));
  endtask

  task automatic test_headers();
    send_header(8'd0, 16'd3);
    send_header(erf_pkg::SUB_DISABLE, 16'd0);
  endtask

  // abandoned header, query mid-list, duplicate id, stray byte, odd trailing byte
  task automatic test_list_collection();
    logic [7:0] list_bytes[$];
    send_header(erf_pkg::SUB_ENABLE, 16'hffff);
    send_header(erf_pkg::SUB_DISABLE, 16'd5);
    send_data(8'd2);
    send_data(8'd0);
    send_query(16'(MAX_IDS));
    send_data(8'(MAX_IDS));
    send_data(8'd0);
    send_data(8'(MAX_IDS));
    send_report(16'(MAX_IDS), 8'd2);
    send_data(8'hff);
    list_bytes.push_back(8'd1);
    list_bytes.push_back(8'd0);
    list_bytes.push_back(8'(MAX_IDS));
    list_bytes.push_back(8'd7);
    send_telecommand(erf_pkg::SUB_ENABLE, 16'd4, list_bytes, 1'b0);
  endtask

  task automatic test_random_traffic();
    int          sel;
    int          cnt;
    int          len;
    int          start_count;
    int          next_pause;
    logic [15:0] id;
    logic [7:0]  sub;
    logic [7:0]  bytes[$];
    start_count = n_items;
    next_pause  = start_count + 400;
    while (n_items < start_count + 1550) begin
      calm = (n_items >= start_count + 700) && (n_items < start_count + 900);
      if (n_items >= next_pause) begin
        hold_until_drained();
        next_pause += 500;
      end
      sel = $urandom_range(99);
      bytes.delete();
      sub = $urandom_range(1) ? erf_pkg::SUB_ENABLE : erf_pkg::SUB_DISABLE;
      if (sel < 35) begin
        send_report(pick_event_id(85), pick_severity());
      end else if (sel < 45) begin
        send_query(pick_event_id(85));
      end else if (sel < 78) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(4, 1);
        bytes.push_back(8'(cnt));
        repeat (cnt) begin
          id = pick_event_id(95);
          bytes.push_back(id[15:8]);
          bytes.push_back(id[7:0]);
        end
        send_telecommand(sub, 16'(1 + 2 * cnt), bytes, 1'b1);
      end else if (sel < 96) begin
        case ($urandom_range(4))
          0: begin
            cnt = $urandom_range(5);
            len = $urandom_range(13, 1);
            bytes.push_back(8'(cnt));
            while (bytes.size() < len) begin
              id = pick_event_id(90);
              bytes.push_back(id[15:8]);
              if (bytes.size() < len)
                bytes.push_back(id[7:0]);
            end
            send_telecommand(sub, 16'(len), bytes, 1'b1);
          end
          1: begin
            bytes.push_back(8'd0);
            send_telecommand(sub, 16'd1, bytes, 1'b0);
          end
          2: begin
            do sub = 8'($urandom);
            while (sub == erf_pkg::SUB_ENABLE || sub == erf_pkg::SUB_DISABLE);
            send_header(sub, 16'($urandom));
          end
          3: send_header(sub, 16'd0);
          default: begin
            len = $urandom_range(16'hffff, 1);
            repeat ($urandom_range(3))
              bytes.push_back(8'($urandom));
            send_telecommand(sub, 16'(len), bytes, 1'b1);
          end
        endcase
      end else begin
        send_data(8'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = erf_pkg::OP_REPORT;
    in_event_id   = '0;
    in_severity   = '0;
    in_aux_word   = '0;
    in_tc_subtype = '0;
    in_tc_length  = '0;
    in_tc_byte    = '0;
    out_ready     = 1'b0;
    calm          = 1'b0;
    mismatches    = 0;
    n_items       = 0;
    n_checked     = 0;
    n_emitted     = 0;
    n_lists_applied = 0;
    enable_mask   = '1;
    clear_collection();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reports();
    test_queries();
    test_headers();
    test_list_collection();
    test_random_traffic();

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (awaited_outcomes.size() != 0)
      report_mismatch("results never delivered", 16'd0, 16'(awaited_outcomes.size()));
    $display("covered %0d items and checked %0d results", n_items, n_checked);
    $display("%0d telemetry records emitted, %0d enable/disable lists applied",
             n_emitted, n_lists_applied);
    if (mismatches == 0)
      $display("event_report_filter test passed");
    else
      $display("event_report_filter test failed");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("event_report_filter test failed");
    $finish;
  end

endmodule
